// ===== design/qse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package qse_pkg;

    // Width of one element.
    localparam int VALUE_W = 32;

    // Operations that the controller asks of the datapath, one per cycle.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_PUSH_ALL,
        OP_POP,
        OP_RANGE,
        OP_PIVOT,
        OP_READ,
        OP_READ_FX,
        OP_SWAP1,
        OP_SWAP2,
        OP_STEP,
        OP_FIX1,
        OP_FIX2,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_EMIT_START,
        OP_EMIT_READ,
        OP_EMIT_NEXT,
        OP_CLEAR
    } t_dp_op;

    // Conditions that the datapath reports back to the controller.
    typedef struct packed {
        logic count_lt2;
        logic sp_zero;
        logic range_bad;
        logic j_eq_hi;
        logic a_less;
        logic push_left;
        logic push_right;
        logic k_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/qse_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one element per transaction.
interface qse_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               final_item;

    modport source (output valid, output value, output final_item, input ready);
    modport sink (input valid, input value, input final_item, output ready);
endinterface

// Output channel: one sorted element per transaction.
interface qse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_value;
    logic               run_end;
    logic               overflow;

    modport source (output valid, output sorted_value, output run_end, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input run_end, input overflow,
                  output ready);
endinterface

`default_nettype wire

// ===== design/qse_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qse_dp
    import qse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_dp_op                     i_op,
    input  wire logic signed [VALUE_W-1:0]  i_value,
    output t_dp_stat                        o_stat,
    output logic signed [VALUE_W-1:0]       o_sorted_value,
    output logic                            o_run_end,
    output logic                            o_overflow
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Element store and range stack, each one write port and registered reads.
    logic signed [VALUE_W-1:0] r_store [DEPTH];
    logic [2*IW-1:0]           r_stack [DEPTH];

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_sp, n_sp;
    logic          r_dropped, n_dropped;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_place, n_place;
    logic [IW-1:0] r_j, n_j;
    logic signed [VALUE_W-1:0] r_pivot, n_pivot;
    logic signed [VALUE_W-1:0] r_rd_a;
    logic signed [VALUE_W-1:0] r_rd_b;
    logic [2*IW-1:0]           r_stk_rd;

    logic                      store_we;
    logic [IW-1:0]             store_wa;
    logic signed [VALUE_W-1:0] store_wd;
    logic                      rd_en;
    logic [IW-1:0]             addr_a;
    logic [IW-1:0]             addr_b;
    logic                      stk_we;
    logic [IW-1:0]             stk_wa;
    logic [2*IW-1:0]           stk_wd;
    logic                      stk_re;
    logic [IW-1:0]             stk_ra;

    logic [CW-1:0] count_m1;
    logic [CW-1:0] sp_m1;
    logic [IW-1:0] stk_lo;
    logic [IW-1:0] stk_hi;

    assign count_m1 = r_count - CW'(1);
    assign sp_m1    = r_sp - CW'(1);
    assign stk_lo   = r_stk_rd[2*IW-1:IW];
    assign stk_hi   = r_stk_rd[IW-1:0];

    // Decode the requested operation into memory strobes and next values.
    always_comb begin
        n_count   = r_count;
        n_sp      = r_sp;
        n_dropped = r_dropped;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_place   = r_place;
        n_j       = r_j;
        n_pivot   = r_pivot;
        store_we  = 1'b0;
        store_wa  = r_place;
        store_wd  = r_rd_a;
        rd_en     = 1'b0;
        addr_a    = r_j;
        addr_b    = r_place;
        stk_we    = 1'b0;
        stk_wa    = r_sp[IW-1:0];
        stk_wd    = {r_lo, r_hi};
        stk_re    = 1'b0;
        stk_ra    = sp_m1[IW-1:0];
        case (i_op)
            OP_LOAD: begin
                if (r_count < CW'(DEPTH)) begin
                    store_we = 1'b1;
                    store_wa = r_count[IW-1:0];
                    store_wd = i_value;
                    n_count  = r_count + CW'(1);
                end else begin
                    n_dropped = 1'b1;
                end
            end
            OP_PUSH_ALL: begin
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = {IW'(0), count_m1[IW-1:0]};
                n_sp   = CW'(1);
            end
            OP_POP: begin
                stk_re = 1'b1;
                n_sp   = sp_m1;
            end
            OP_RANGE: begin
                n_lo   = stk_lo;
                n_hi   = stk_hi;
                rd_en  = 1'b1;
                addr_a = stk_hi;
            end
            OP_PIVOT: begin
                n_pivot = r_rd_a;
                n_place = r_lo;
                n_j     = r_lo;
            end
            OP_READ: begin
                rd_en  = 1'b1;
                addr_a = r_j;
                addr_b = r_place;
            end
            OP_READ_FX: begin
                rd_en  = 1'b1;
                addr_a = r_place;
                addr_b = r_hi;
            end
            OP_SWAP1: begin
                store_we = 1'b1;
                store_wa = r_place;
                store_wd = r_rd_a;
            end
            OP_SWAP2: begin
                store_we = 1'b1;
                store_wa = r_j;
                store_wd = r_rd_b;
                n_place  = r_place + IW'(1);
                n_j      = r_j + IW'(1);
            end
            OP_STEP: begin
                n_j = r_j + IW'(1);
            end
            OP_FIX1: begin
                store_we = 1'b1;
                store_wa = r_place;
                store_wd = r_rd_b;
            end
            OP_FIX2: begin
                store_we = 1'b1;
                store_wa = r_hi;
                store_wd = r_rd_a;
            end
            OP_PUSH_L: begin
                if (r_sp < CW'(DEPTH)) begin
                    stk_we = 1'b1;
                    stk_wd = {r_lo, r_place - IW'(1)};
                    n_sp   = r_sp + CW'(1);
                end
            end
            OP_PUSH_R: begin
                if (r_sp < CW'(DEPTH)) begin
                    stk_we = 1'b1;
                    stk_wd = {r_place + IW'(1), r_hi};
                    n_sp   = r_sp + CW'(1);
                end
            end
            OP_EMIT_START: begin
                n_j = '0;
            end
            OP_EMIT_READ: begin
                rd_en  = 1'b1;
                addr_a = r_j;
            end
            OP_EMIT_NEXT: begin
                n_j = r_j + IW'(1);
            end
            OP_CLEAR: begin
                n_count   = '0;
                n_sp      = '0;
                n_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Control counters and the drop flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sp      <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_sp      <= n_sp;
            r_dropped <= n_dropped;
        end
    end

    // Partition indices and the pivot value.
    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_place <= n_place;
        r_j     <= n_j;
        r_pivot <= n_pivot;
    end

    // Element store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_wa] <= store_wd;
        end
        if (rd_en) begin
            r_rd_a <= r_store[addr_a];
            r_rd_b <= r_store[addr_b];
        end
    end

    // Range stack: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stack[stk_ra];
        end
    end

    // Status back to the controller.
    always_comb begin
        o_stat.count_lt2  = r_count < CW'(2);
        o_stat.sp_zero    = r_sp == '0;
        o_stat.range_bad  = stk_lo >= stk_hi;
        o_stat.j_eq_hi    = r_j == r_hi;
        o_stat.a_less     = r_rd_a < r_pivot;
        o_stat.push_left  = CW'(r_place) > CW'(r_lo) + CW'(1);
        o_stat.push_right = CW'(r_place) + CW'(1) < CW'(r_hi);
        o_stat.k_last     = CW'(r_j) + CW'(1) == r_count;
    end

    assign o_sorted_value = r_rd_a;
    assign o_run_end      = o_stat.k_last;
    assign o_overflow     = r_dropped;

    // Disjoint ranges of two or more elements bound the stack at half the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= CW'(DEPTH / 2))
        else $error("range stack deeper than half the store");

    // The store never holds more than its capacity.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond capacity");

    // During a partition scan the indices stay ordered inside the range.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_READ) |-> (r_lo <= r_place && r_place <= r_j && r_j < r_hi))
        else $error("partition indices out of order");

    // A pop is only asked for when a range is pending.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_POP) |-> (r_sp != '0))
        else $error("pop from an empty range stack");

    // Emission only reads stored entries.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_EMIT_READ) |-> (CW'(r_j) < r_count))
        else $error("emission reads past the stored elements");

endmodule

`default_nettype wire

// ===== design/qse_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module qse_ctrl
    import qse_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_final_item,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_op        o_op
);

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_POP,
        S_RANGE,
        S_PIVOT,
        S_LOOP,
        S_CMP,
        S_SWAP,
        S_FIX1,
        S_FIX2,
        S_PUSHL,
        S_PUSHR,
        S_EMIT_RD,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   in_acc;
    logic   out_acc;

    assign in_acc  = i_in_valid & r_in_ready;
    assign out_acc = r_out_valid & i_out_ready;

    // Operation issued to the datapath in the current state.
    always_comb begin
        o_op = OP_IDLE;
        case (r_state)
            S_LOAD:    o_op = in_acc ? OP_LOAD : OP_IDLE;
            S_START:   o_op = i_stat.count_lt2 ? OP_EMIT_START : OP_PUSH_ALL;
            S_POP:     o_op = i_stat.sp_zero ? OP_EMIT_START : OP_POP;
            S_RANGE:   o_op = OP_RANGE;
            S_PIVOT:   o_op = OP_PIVOT;
            S_LOOP:    o_op = i_stat.j_eq_hi ? OP_READ_FX : OP_READ;
            S_CMP:     o_op = i_stat.a_less ? OP_SWAP1 : OP_STEP;
            S_SWAP:    o_op = OP_SWAP2;
            S_FIX1:    o_op = OP_FIX1;
            S_FIX2:    o_op = OP_FIX2;
            S_PUSHL:   o_op = i_stat.push_left ? OP_PUSH_L : OP_IDLE;
            S_PUSHR:   o_op = i_stat.push_right ? OP_PUSH_R : OP_IDLE;
            S_EMIT_RD: o_op = OP_EMIT_READ;
            S_EMIT: begin
                if (out_acc) begin
                    o_op = i_stat.k_last ? OP_CLEAR : OP_EMIT_NEXT;
                end
            end
            default:   o_op = OP_IDLE;
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_LOAD: begin
                    if (in_acc && i_final_item) begin
                        r_state    <= S_START;
                        r_in_ready <= 1'b0;
                    end
                end
                S_START: begin
                    r_state <= i_stat.count_lt2 ? S_EMIT_RD : S_POP;
                end
                S_POP: begin
                    r_state <= i_stat.sp_zero ? S_EMIT_RD : S_RANGE;
                end
                S_RANGE: begin
                    r_state <= i_stat.range_bad ? S_POP : S_PIVOT;
                end
                S_PIVOT: begin
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    r_state <= i_stat.j_eq_hi ? S_FIX1 : S_CMP;
                end
                S_CMP: begin
                    r_state <= i_stat.a_less ? S_SWAP : S_LOOP;
                end
                S_SWAP: begin
                    r_state <= S_LOOP;
                end
                S_FIX1: begin
                    r_state <= S_FIX2;
                end
                S_FIX2: begin
                    r_state <= S_PUSHL;
                end
                S_PUSHL: begin
                    r_state <= S_PUSHR;
                end
                S_PUSHR: begin
                    r_state <= S_POP;
                end
                S_EMIT_RD: begin
                    r_state     <= S_EMIT;
                    r_out_valid <= 1'b1;
                end
                S_EMIT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        if (i_stat.k_last) begin
                            r_state    <= S_LOAD;
                            r_in_ready <= 1'b1;
                        end else begin
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state     <= S_LOAD;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== design/quicksort_engine.sv =====
// Loads a set of signed 32-bit values, one per input transaction, into an on-chip store of
// DEPTH entries; the transaction with final_item set closes the set, and values beyond
// DEPTH are dropped and reported through overflow on every result of that run. The set
// is then sorted in place by quicksort (last element as pivot, Lomuto partition) with an
// explicit range stack, and emitted in ascending order, one result per stored element,
// with run_end on the last. Loading accepts one element per cycle. The sort is paced by the
// single write port of the element store: each scanned element is read and compared, an
// element swapped forward needs a second write, and each partition adds setup, pivot
// exchange and stack traffic. Each result is read from the store and then offered, and
// the next read waits until that result is taken. Input is not accepted from the final
// transaction until the last result has been taken.
`timescale 1ns / 1ps
`default_nettype none

module quicksort_engine
    import qse_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qse_in_if.sink     i_in,
    qse_out_if.source  o_out
);

    t_dp_op   op;
    t_dp_stat stat;

    // Sequencer for load, partition, stack and emission steps.
    qse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_final_item (i_in.final_item),
        .i_out_ready  (o_out.ready),
        .i_stat       (stat),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .o_op         (op)
    );

    // Element store, range stack and partition indices.
    qse_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_value        (i_in.value),
        .o_stat         (stat),
        .o_sorted_value (o_out.sorted_value),
        .o_run_end      (o_out.run_end),
        .o_overflow     (o_out.overflow)
    );

endmodule

`default_nettype wire

// ===== verif/quicksort_engine_tb.sv =====
`timescale 1ns / 1ps

module quicksort_engine_tb;
    import qse_pkg::*;

    localparam int STORE_DEPTH  = 64;
    localparam int ITEM_TARGET  = 380;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int N_DIRECTED   = 20;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // One sorted element as it leaves the block.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      run_end;
        logic                      overflow;
    } t_sorted_rec;

    // One row of the directed table; want is used only when fixed_want is set.
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
        logic                      fixed_want;
        t_sorted_rec               want;
    } t_stim_row;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_CORNER,
        FILL_RISING,
        FILL_FALLING,
        FILL_FLAT
    } t_fill_kind;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SLOW,
        RX_HOLD
    } t_rx_mode;

    localparam t_sorted_rec NO_WANT = '0;

    logic i_clk;
    logic i_rst_n;

    qse_in_if  in_if ();
    qse_out_if out_if ();

    quicksort_engine #(
        .DEPTH (STORE_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Single-element sets carry a fixed expectation; every other row goes through
    // the sorting model.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{VAL_MIN,  1'b1, 1'b1, '{VAL_MIN,  1'b1, 1'b0}},
        '{VAL_MAX,  1'b1, 1'b1, '{VAL_MAX,  1'b1, 1'b0}},
        '{32'sd0,   1'b1, 1'b1, '{32'sd0,   1'b1, 1'b0}},
        '{-32'sd1,  1'b1, 1'b1, '{-32'sd1,  1'b1, 1'b0}},
        '{VAL_MAX,  1'b0, 1'b0, NO_WANT},
        '{VAL_MIN,  1'b1, 1'b0, NO_WANT},
        '{32'sd7,   1'b0, 1'b0, NO_WANT},
        '{32'sd7,   1'b1, 1'b0, NO_WANT},
        '{32'sd3,   1'b0, 1'b0, NO_WANT},
        '{32'sd2,   1'b0, 1'b0, NO_WANT},
        '{32'sd1,   1'b1, 1'b0, NO_WANT},
        '{-32'sd5,  1'b0, 1'b0, NO_WANT},
        '{32'sd0,   1'b0, 1'b0, NO_WANT},
        '{32'sd5,   1'b1, 1'b0, NO_WANT},
        '{VAL_MAX,  1'b0, 1'b0, NO_WANT},
        '{VAL_MIN,  1'b0, 1'b0, NO_WANT},
        '{-32'sd1,  1'b0, 1'b0, NO_WANT},
        '{VAL_MAX,  1'b0, 1'b0, NO_WANT},
        '{32'sd0,   1'b0, 1'b0, NO_WANT},
        '{VAL_MIN,  1'b1, 1'b0, NO_WANT}
    };

    // Model of the element store and the sorted results still owed by the block.
    logic signed [VALUE_W-1:0] model_store [STORE_DEPTH];
    int                        model_held;
    bit                        model_spilled;
    t_sorted_rec               sorted_due [$];

    int   fault_count;
    int   items_sent;
    int   sets_closed;
    int   spill_runs;
    int   results_checked;
    int   cycle_count;
    int   burst_left;
    bit   sender_gaps;
    logic hold_flip = 1'b0;

    // Clock with an 8 ns period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void exchange_entries(int a, int b);
        logic signed [VALUE_W-1:0] tmp;
        tmp            = model_store[a];
        model_store[a] = model_store[b];
        model_store[b] = tmp;
    endfunction

    // Store one accepted element; on the last one of a set, sort the store by
    // Lomuto quicksort with an explicit range stack and queue the sorted results.
    function automatic void absorb_element(logic signed [VALUE_W-1:0] v, logic last,
                                           logic fixed_want, t_sorted_rec want);
        logic [11:0]               pending [STORE_DEPTH];
        logic signed [VALUE_W-1:0] pivot;
        t_sorted_rec               rec;
        int                        sp;
        int                        lo;
        int                        hi;
        int                        place;

        if (model_held < STORE_DEPTH) begin
            model_store[model_held] = v;
            model_held++;
        end else begin
            model_spilled = 1'b1;
        end
        if (!last) begin
            return;
        end

        sp = 0;
        if (model_held >= 2) begin
            pending[0] = {6'(0), 6'(model_held - 1)};
            sp = 1;
        end
        while (sp > 0) begin
            sp--;
            lo = int'(pending[sp][11:6]);
            hi = int'(pending[sp][5:0]);
            if (lo >= hi) begin
                continue;
            end
            pivot = model_store[hi];
            place = lo;
            for (int j = lo; j < hi; j++) begin
                if (model_store[j] < pivot) begin
                    exchange_entries(place, j);
                    place++;
                end
            end
            exchange_entries(place, hi);
            if (place > lo + 1) begin
                pending[sp] = {6'(lo), 6'(place - 1)};
                sp++;
            end
            if (place + 1 < hi) begin
                pending[sp] = {6'(place + 1), 6'(hi)};
                sp++;
            end
        end

        if (fixed_want) begin
            sorted_due.push_back(want);
        end else begin
            for (int k = 0; k < model_held; k++) begin
                rec.value    = model_store[k];
                rec.run_end  = (k == model_held - 1);
                rec.overflow = model_spilled;
                sorted_due.push_back(rec);
            end
        end
        sets_closed++;
        if (model_spilled) begin
            spill_runs++;
        end
        model_held    = 0;
        model_spilled = 1'b0;
    endfunction

    // Offer one element, inserting an idle gap at the start of each burst when sender_gaps
    // is set, and record it once the transaction completes.
    task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic last,
                                input logic fixed_want, input t_sorted_rec want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid      <= 1'b1;
        in_if.value      <= v;
        in_if.final_item <= last;
        forever begin
            @(posedge i_clk);
            if (in_if.valid && in_if.ready) begin
                break;
            end
        end
        items_sent++;
        absorb_element(v, last, fixed_want, want);
    endtask

    // Send a whole set whose contents follow the given fill pattern.
    task automatic send_set(input int size, input t_fill_kind kind);
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] v;
        int                        step;
        base = $urandom;
        step = $urandom_range(1, 1000);
        if (kind == FILL_RISING || kind == FILL_FALLING) begin
            base = int'($urandom_range(0, 2000000)) - 1000000;
        end
        for (int k = 0; k < size; k++) begin
            case (kind)
                FILL_RANDOM: begin
                    v = $urandom;
                end
                FILL_NARROW: begin
                    v = int'($urandom_range(0, 8)) - 4;
                end
                FILL_CORNER: begin
                    case ($urandom_range(0, 4))
                        0: v = VAL_MIN;
                        1: v = VAL_MAX;
                        2: v = 32'sd0;
                        3: v = -32'sd1;
                        default: v = $urandom;
                    endcase
                end
                FILL_RISING: begin
                    v = base + k * step;
                end
                FILL_FALLING: begin
                    v = base - k * step;
                end
                default: begin
                    v = base;
                end
            endcase
            send_element(v, k == size - 1, 1'b0, NO_WANT);
        end
    endtask

    // Stimulus: reset, directed table, a long receiver hold-off, then random sets.
    initial begin : stimulus
        t_stim_row row;
        int        pick;
        int        size;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.value      <= '0;
        in_if.final_item <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_gaps = 1'b1;
        for (int n = 0; n < N_DIRECTED; n++) begin
            row = directed_rows[n];
            send_element(row.value, row.last, row.fixed_want, row.want);
        end

        // The receiver holds off while the last directed set is still owed, which also holds back this set.
        hold_flip <= ~hold_flip;
        send_set(48, FILL_RANDOM);

        // Mostly small sets, some full ones and some that overrun the store.
        while (items_sent < ITEM_TARGET) begin
            sender_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                size = $urandom_range(1, 12);
            end else if (pick < 85) begin
                size = $urandom_range(13, 40);
            end else if (pick < 93) begin
                size = STORE_DEPTH;
            end else begin
                size = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 8);
            end
            send_set(size, t_fill_kind'($urandom_range(0, 5)));
        end
        in_if.valid <= 1'b0;

        while (sorted_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sorted %0d sets from %0d input transactions, %0d of them overrunning the store.",
                 sets_closed, items_sent, spill_runs);
        $display("Checked %0d output transactions under bursty input and random output stalls.",
                 results_checked);
        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Receiver: changes stall pattern after a random span and serves a long
    // hold-off whenever the stimulus asks for one.
    initial begin : receiver
        t_rx_mode mode;
        int       span;
        logic     hold_seen;

        hold_seen = 1'b0;
        mode      = RX_OPEN;
        span      = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_flip != hold_seen) begin
                hold_seen = hold_flip;
                mode      = RX_HOLD;
                span      = LONG_HOLD;
            end else if (span == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                span = $urandom_range(4, 60);
            end
            span--;
            case (mode)
                RX_OPEN: out_if.ready <= 1'b1;
                RX_COIN: out_if.ready <= 1'($urandom_range(0, 1));
                RX_SLOW: out_if.ready <= ($urandom_range(0, 3) == 0);
                default: out_if.ready <= 1'b0;
            endcase
        end
    end

    // Compare each output transaction with the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_sorted_rec due;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_checked++;
            if (sorted_due.size() == 0) begin
                fault_count++;
                $display("%0t: unexpected result: expected none, got value %0d end %0b ovf %0b",
                         $time, out_if.sorted_value, out_if.run_end, out_if.overflow);
            end else begin
                due = sorted_due.pop_front();
                if (out_if.sorted_value !== due.value) begin
                    fault_count++;
                    $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                             $time, due.value, out_if.sorted_value);
                end
                if (out_if.run_end !== due.run_end) begin
                    fault_count++;
                    $display("%0t: run_end mismatch: expected %0b, got %0b",
                             $time, due.run_end, out_if.run_end);
                end
                if (out_if.overflow !== due.overflow) begin
                    fault_count++;
                    $display("%0t: overflow mismatch: expected %0b, got %0b",
                             $time, due.overflow, out_if.overflow);
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still owed", $time, sorted_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
